### hw/rtl/tsct_pkg.sv
// Package for the TCP server connection tracker.
// Types, codes and sizes shared by the interfaces and all modules.
`timescale 1ns / 1ps
package tsct_pkg;
  localparam int CONN_ENTRIES = 16;
  localparam int IDX_W = $clog2(CONN_ENTRIES);
  localparam int CNT_W = $clog2(CONN_ENTRIES + 1);

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  localparam logic [2:0] ST_SYN_RCVD = 3'd1;
  localparam logic [2:0] ST_ESTABLISHED = 3'd2;
  localparam logic [2:0] ST_CLOSE_WAIT = 3'd3;
  localparam logic [2:0] ST_LAST_ACK = 3'd4;

  localparam logic [2:0] RS_HANDLED = 3'd0;
  localparam logic [2:0] RS_ACCEPTED = 3'd1;
  localparam logic [2:0] RS_FREED = 3'd2;
  localparam logic [2:0] RS_BAD_CSUM = 3'd3;
  localparam logic [2:0] RS_NO_MATCH = 3'd4;
  localparam logic [2:0] RS_TABLE_FULL = 3'd5;

  localparam logic [1:0] CFG_LISTEN_PORT = 2'd0;
  localparam logic [1:0] CFG_LISTEN_ENABLE = 2'd1;
  localparam logic [1:0] CFG_WINDOW = 2'd2;

  typedef struct packed {
    logic        action;
    logic [3:0]  conn_index;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flags;
    logic [15:0] payload_length;
    logic        checksum_ok;
    logic [31:0] initial_seq;
  } seg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  conn_index_res;
    logic        reply_valid;
    logic [7:0]  reply_flags;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dst_port;
    logic [15:0] reply_window;
    logic        deliver_valid;
    logic [15:0] deliver_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] remote_addr;
    logic [31:0] local_addr;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic [2:0]  conn_state;
    logic [31:0] send_next;
    logic [31:0] receive_next;
  } entry_t;
endpackage

### hw/rtl/tsct_seg_if.sv
// Valid/ready channel interfaces for segment words and result words.
// Depends on tsct_pkg.
`timescale 1ns / 1ps
interface tsct_seg_if import tsct_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  seg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsct_res_if import tsct_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tsct_table_ram.sv
// Connection table memory, one write and one registered read port.
// Depends on tsct_pkg.
`timescale 1ns / 1ps
module tsct_table_ram import tsct_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);
  entry_t mem [CONN_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/tcp_server_connection_tracker.sv
// TCP server connection tracker, top level.
// Depends on tsct_pkg, tsct_seg_if/tsct_res_if and tsct_table_ram.
//
// Usage: segment and close words enter on seg (valid/ready); one or two
// result words leave on res, the final one carrying last. The user sets registers
// through cfg_we/cfg_index/cfg_data while the block is idle; the block does not enforce this.
// One item is processed at a time. A segment scans the table one entry per
// cycle through the single read port of the table memory, then reads and
// updates the matched or allocated entry. A close item reads its indexed entry
// without a scan; a bad checksum or a close of a free entry goes straight to
// its result word.
// Entry valid bits live in flip-flops; reset clears them and the registers
// at once, no clearing pass. The table contents are undefined until written.
// When res is stalled the result word holds and no new item is taken.
`timescale 1ns / 1ps
module tcp_server_connection_tracker import tsct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tsct_seg_if.sink    seg,
  tsct_res_if.source  res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_OUT1 = 3'd4;
  localparam logic [2:0] S_OUT2 = 3'd5;

  logic [2:0] state;
  logic [15:0] listen_port;
  logic listen_enable;
  logic [15:0] window;
  logic [CONN_ENTRIES-1:0] entry_valid;
  seg_t item;
  logic [CNT_W-1:0] scan;
  logic scan_rd;
  logic [IDX_W-1:0] scan_idx;
  logic found;
  logic [IDX_W-1:0] hit;
  res_t r1, r2;
  logic two;

  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t wdata, rdata;

  tsct_table_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  assign seg.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT1) || (state == S_OUT2);
  assign res.data = (state == S_OUT2) ? r2 : r1;

  always_comb begin
    raddr = scan[IDX_W-1:0];
    if (state == S_READ) begin
      raddr = hit;
    end
  end

  function automatic res_t mk(logic [2:0] st, logic [IDX_W-1:0] idx, logic [7:0] fl,
    logic [31:0] sq, logic [31:0] ak, logic [15:0] lp, logic [15:0] rp,
    logic dv, logic [15:0] dl, logic [15:0] win, logic lst);
    res_t r;
    r.status = st;
    r.conn_index_res = 4'(idx);
    r.reply_valid = (fl != 8'd0);
    r.reply_flags = fl;
    r.reply_seq = r.reply_valid ? sq : 32'd0;
    r.reply_ack = r.reply_valid ? ak : 32'd0;
    r.reply_src_port = r.reply_valid ? lp : 16'd0;
    r.reply_dst_port = r.reply_valid ? rp : 16'd0;
    r.reply_window = r.reply_valid ? win : 16'd0;
    r.deliver_valid = dv;
    r.deliver_length = dv ? dl : 16'd0;
    r.last = lst;
    return r;
  endfunction

  logic [IDX_W-1:0] free_idx;
  logic free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = CONN_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  logic [31:0] rcv_a, rcv_b;
  assign rcv_a = rdata.receive_next + {16'd0, item.payload_length};
  assign rcv_b = ((item.flags & FL_PSH) != 8'd0) ? rcv_a + 32'd1
                                                 : rdata.receive_next + 32'd1;

  always_comb begin
    we = 1'b0;
    waddr = hit;
    wdata = rdata;
    if (state == S_EXEC) begin
      if (item.action) begin
        we = 1'b1;
        wdata.conn_state = ST_LAST_ACK;
      end else if (found) begin
        if (rdata.conn_state == ST_SYN_RCVD && (item.flags & FL_ACK) != 8'd0) begin
          we = 1'b1;
          wdata.conn_state = ST_ESTABLISHED;
        end else if (rdata.conn_state == ST_ESTABLISHED) begin
          if ((item.flags & FL_PSH) != 8'd0) begin
            we = 1'b1;
            wdata.receive_next = rcv_a;
            wdata.send_next = item.ack_num;
          end
          if ((item.flags & FL_FIN) != 8'd0) begin
            we = 1'b1;
            wdata.receive_next = rcv_b;
            wdata.send_next = item.ack_num;
            wdata.conn_state = ST_CLOSE_WAIT;
          end
        end
      end else begin
        we = listen_enable && item.dport == listen_port &&
             (item.flags & FL_SYN) != 8'd0 && free_any;
        waddr = free_idx;
        wdata.remote_addr = item.src_ip;
        wdata.local_addr = item.dst_ip;
        wdata.remote_port = item.sport;
        wdata.local_port = item.dport;
        wdata.conn_state = ST_SYN_RCVD;
        wdata.send_next = item.initial_seq + 32'd1;
        wdata.receive_next = item.seq_num + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      listen_port <= 16'd0;
      listen_enable <= 1'b0;
      window <= 16'hFFFF;
      entry_valid <= '0;
      scan <= '0;
      scan_rd <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LISTEN_PORT: listen_port <= cfg_data;
          CFG_LISTEN_ENABLE: listen_enable <= cfg_data[0];
          CFG_WINDOW: window <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            item <= seg.data;
            found <= 1'b0;
            two <= 1'b0;
            if (seg.data.action) begin
              hit <= seg.data.conn_index[IDX_W-1:0];
              if (!entry_valid[seg.data.conn_index[IDX_W-1:0]]) begin
                r1 <= mk(RS_NO_MATCH, '0, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
                state <= S_OUT1;
              end else begin
                state <= S_READ;
              end
            end else if (!seg.data.checksum_ok) begin
              r1 <= mk(RS_BAD_CSUM, '0, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
              state <= S_OUT1;
            end else begin
              scan <= '0;
              scan_rd <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          scan_rd <= (scan < CNT_W'(CONN_ENTRIES));
          scan_idx <= scan[IDX_W-1:0];
          if (scan < CNT_W'(CONN_ENTRIES)) begin
            scan <= scan + CNT_W'(1);
          end
          if (scan_rd && !found && entry_valid[scan_idx] &&
              rdata.remote_addr == item.src_ip && rdata.local_addr == item.dst_ip &&
              rdata.remote_port == item.sport && rdata.local_port == item.dport) begin
            found <= 1'b1;
            hit <= scan_idx;
          end
          if (!scan_rd && scan == CNT_W'(CONN_ENTRIES)) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          state <= S_OUT1;
          if (item.action) begin
            r1 <= mk(RS_HANDLED, hit, FL_FIN | FL_ACK, rdata.send_next, rdata.receive_next,
                     rdata.local_port, rdata.remote_port, 1'b0, '0, window, 1'b1);
          end else if (found) begin
            if (rdata.conn_state == ST_SYN_RCVD && (item.flags & FL_ACK) != 8'd0) begin
              r1 <= mk(RS_ACCEPTED, hit, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
            end else if (rdata.conn_state == ST_ESTABLISHED &&
                         (item.flags & FL_PSH) != 8'd0) begin
              r1 <= mk(RS_HANDLED, hit, FL_ACK, item.ack_num, rcv_a, rdata.local_port,
                       rdata.remote_port, 1'b1, item.payload_length, window,
                       (item.flags & FL_FIN) == 8'd0);
              two <= (item.flags & FL_FIN) != 8'd0;
              r2 <= mk(RS_HANDLED, hit, FL_ACK, item.ack_num, rcv_b, rdata.local_port,
                       rdata.remote_port, 1'b1, '0, window, 1'b1);
            end else if (rdata.conn_state == ST_ESTABLISHED &&
                         (item.flags & FL_FIN) != 8'd0) begin
              r1 <= mk(RS_HANDLED, hit, FL_ACK, item.ack_num, rcv_b, rdata.local_port,
                       rdata.remote_port, 1'b1, '0, window, 1'b1);
            end else if (rdata.conn_state == ST_LAST_ACK &&
                         (item.flags & FL_ACK) != 8'd0) begin
              entry_valid[hit] <= 1'b0;
              r1 <= mk(RS_FREED, hit, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
            end else begin
              r1 <= mk(RS_HANDLED, hit, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
            end
          end else if (listen_enable && item.dport == listen_port) begin
            if ((item.flags & FL_SYN) == 8'd0) begin
              r1 <= mk(RS_HANDLED, '0, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
            end else if (!free_any) begin
              r1 <= mk(RS_TABLE_FULL, '0, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
            end else begin
              entry_valid[free_idx] <= 1'b1;
              r1 <= mk(RS_HANDLED, free_idx, FL_SYN | FL_ACK, item.initial_seq,
                       item.seq_num + 32'd1, item.dport, item.sport, 1'b0, '0, window,
                       1'b1);
            end
          end else begin
            r1 <= mk(RS_NO_MATCH, '0, 8'd0, '0, '0, '0, '0, 1'b0, '0, window, 1'b1);
          end
        end
        S_OUT1: begin
          if (res.ready) begin
            state <= two ? S_OUT2 : S_IDLE;
          end
        end
        S_OUT2: begin
          if (res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/tb.sv
// Testbench for the TCP server connection tracker.
// Drives segment and close words, predicts result words and compares them.
// Depends on tsct_pkg, tsct_seg_if/tsct_res_if and the tracker RTL.
`timescale 1ns / 1ps
module tb;
  import tsct_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_LISTEN_PORT;
  logic [15:0] cfg_data = 16'd0;

  tsct_seg_if seg (clk);
  tsct_res_if res (clk);

  tcp_server_connection_tracker DUT (
    .clk(clk), .rst(rst), .seg(seg.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tracker shadow
  logic        sh_valid [CONN_ENTRIES];
  entry_t      sh_tab [CONN_ENTRIES];
  logic [15:0] sh_lport;
  logic        sh_len;
  logic [15:0] sh_win;

  seg_t seg_q[$];
  res_t res_q[$];
  int errors = 0;
  int sent = 0;
  int burst = 0;
  int gap = 0;
  int stall_ph = 0;

  // peers of established-ish connections; this queue is not used by the bench
  seg_t peer_q[$];

  task automatic report(string what, res_t got, res_t exp);
    $display("mismatch %s: got %h exp %h", what, got, exp);
    errors++;
  endtask

  function automatic res_t mk(logic [2:0] st, logic [3:0] idx, logic [7:0] fl,
                              logic [31:0] sq, logic [31:0] ak, logic [15:0] lp,
                              logic [15:0] rp, logic dv, logic [15:0] dl);
    res_t r;
    r = '0;
    r.status = st;
    r.conn_index_res = idx;
    r.reply_valid = (fl != 8'd0);
    r.reply_flags = fl;
    if (fl != 8'd0) begin
      r.reply_seq = sq; r.reply_ack = ak;
      r.reply_src_port = lp; r.reply_dst_port = rp;
      r.reply_window = sh_win;
    end
    r.deliver_valid = dv;
    r.deliver_length = dv ? dl : 16'd0;
    return r;
  endfunction

  function automatic res_t nr(logic [2:0] st, logic [3:0] idx);
    return mk(st, idx, '0, '0, '0, '0, '0, 1'b0, '0);
  endfunction

  task automatic track(seg_t s);
    res_t out[$];
    res_t r;
    int i;
    int m;
    m = -1;
    if (s.action) begin
      i = s.conn_index;
      if (!sh_valid[i]) out.push_back(nr(RS_NO_MATCH, 4'd0));
      else begin
        out.push_back(mk(RS_HANDLED, 4'(i), FL_FIN | FL_ACK, sh_tab[i].send_next,
          sh_tab[i].receive_next, sh_tab[i].local_port, sh_tab[i].remote_port, 1'b0, '0));
        sh_tab[i].conn_state = ST_LAST_ACK;
      end
    end else if (!s.checksum_ok) begin
      out.push_back(nr(RS_BAD_CSUM, 4'd0));
    end else begin
      for (i = CONN_ENTRIES - 1; i >= 0; i--)
        if (sh_valid[i] && sh_tab[i].remote_addr == s.src_ip &&
            sh_tab[i].local_addr == s.dst_ip && sh_tab[i].remote_port == s.sport &&
            sh_tab[i].local_port == s.dport) m = i;
      if (m >= 0) begin
        if (sh_tab[m].conn_state == ST_SYN_RCVD && (s.flags & FL_ACK)) begin
          sh_tab[m].conn_state = ST_ESTABLISHED;
          out.push_back(nr(RS_ACCEPTED, 4'(m)));
        end else if (sh_tab[m].conn_state == ST_ESTABLISHED) begin
          if (s.flags & FL_PSH) begin
            sh_tab[m].receive_next += {16'd0, s.payload_length};
            sh_tab[m].send_next = s.ack_num;
            out.push_back(mk(RS_HANDLED, 4'(m), FL_ACK, sh_tab[m].send_next,
              sh_tab[m].receive_next, sh_tab[m].local_port, sh_tab[m].remote_port, 1'b1,
              s.payload_length));
          end
          if (s.flags & FL_FIN) begin
            sh_tab[m].conn_state = ST_CLOSE_WAIT;
            sh_tab[m].receive_next += 32'd1;
            sh_tab[m].send_next = s.ack_num;
            out.push_back(mk(RS_HANDLED, 4'(m), FL_ACK, sh_tab[m].send_next,
              sh_tab[m].receive_next, sh_tab[m].local_port, sh_tab[m].remote_port, 1'b1,
              '0));
          end
          if (out.size() == 0) out.push_back(nr(RS_HANDLED, 4'(m)));
        end else if (sh_tab[m].conn_state == ST_LAST_ACK && (s.flags & FL_ACK)) begin
          sh_valid[m] = 1'b0;
          out.push_back(nr(RS_FREED, 4'(m)));
        end else out.push_back(nr(RS_HANDLED, 4'(m)));
      end else if (sh_len && s.dport == sh_lport) begin
        if (s.flags & FL_SYN) begin
          for (i = CONN_ENTRIES - 1; i >= 0; i--) if (!sh_valid[i]) m = i;
          if (m < 0) out.push_back(nr(RS_TABLE_FULL, 4'd0));
          else begin
            sh_valid[m] = 1'b1;
            sh_tab[m].remote_addr = s.src_ip;
            sh_tab[m].local_addr = s.dst_ip;
            sh_tab[m].remote_port = s.sport;
            sh_tab[m].local_port = s.dport;
            sh_tab[m].conn_state = ST_SYN_RCVD;
            sh_tab[m].send_next = s.initial_seq + 32'd1;
            sh_tab[m].receive_next = s.seq_num + 32'd1;
            out.push_back(mk(RS_HANDLED, 4'(m), FL_SYN | FL_ACK, s.initial_seq,
              s.seq_num + 32'd1, s.dport, s.sport, 1'b0, '0));
          end
        end else out.push_back(nr(RS_HANDLED, 4'd0));
      end else out.push_back(nr(RS_NO_MATCH, 4'd0));
    end
    out[out.size() - 1].last = 1'b1;
    foreach (out[k]) res_q.push_back(out[k]);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
      seg.data <= '0;
      burst <= 0;
      gap <= 0;
    end else if (seg.valid && seg.ready) begin
      track(seg.data);
      sent <= sent + 1;
      if (seg_q.size() > 0 && burst > 0) begin
        seg.data <= seg_q.pop_front();
        burst <= burst - 1;
      end else begin
        seg.valid <= 1'b0;
        gap <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
      end
    end else if (!seg.valid) begin
      if (gap > 0) gap <= gap - 1;
      else if (seg_q.size() > 0) begin
        seg.valid <= 1'b1;
        seg.data <= seg_q.pop_front();
        burst <= $urandom_range(0, 8);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      stall_ph <= 0;
    end else begin
      stall_ph <= stall_ph + 1;
      if (stall_ph % 256 < 100) res.ready <= 1'b1;
      else res.ready <= ($urandom_range(0, 2) != 0) && (stall_ph % 7 != 3);
      if (res.valid && res.ready) begin
        if (res_q.size() == 0) report("unexpected", res.data, '0);
        else begin
          res_t e;
          e = res_q.pop_front();
          if (res.data !== e) report("word", res.data, e);
        end
      end
    end
  end

  task automatic wr_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LISTEN_PORT: sh_lport = val;
      CFG_LISTEN_ENABLE: sh_len = val[0];
      default: sh_win = val;
    endcase
  endtask

  task automatic drain();
    wait (seg_q.size() == 0 && !seg.valid && res_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  function automatic seg_t rnd_seg();
    seg_t s;
    logic [223:0] w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    s = w[$bits(seg_t)-1:0];
    return s;
  endfunction

  // connection sequence: SYN, ACK, data with random flags, optional close of entry 0-3, optional final ACK
  task automatic conn_seq(logic [15:0] lp, int nd);
    seg_t s, b;
    b = rnd_seg();
    b.action = 1'b0; b.checksum_ok = 1'b1; b.dport = lp;
    if ($urandom_range(0, 3) == 0) begin
      b.src_ip = $urandom_range(0, 3); b.sport = 16'($urandom_range(0, 3));
    end
    s = b; s.flags = FL_SYN | ($urandom_range(0, 1) ? 8'h00 : 8'hE4);
    seg_q.push_back(s);
    s = b; s.flags = FL_ACK | 8'($urandom_range(0, 255)); seg_q.push_back(s);
    repeat (nd) begin
      s = b; s.seq_num = $urandom; s.ack_num = $urandom;
      s.flags = 8'($urandom_range(0, 255)); s.payload_length = 16'($urandom);
      if ($urandom_range(0, 9) == 0) s.checksum_ok = 1'b0;
      seg_q.push_back(s);
    end
    if ($urandom_range(0, 2) == 0) begin
      s = rnd_seg(); s.action = 1'b1; s.conn_index = 4'($urandom_range(0, 3));
      seg_q.push_back(s);
    end
    if ($urandom_range(0, 3) != 0) begin
      s = b; s.flags = FL_ACK; seg_q.push_back(s);
    end
  endtask

  initial begin
    seg_t s;
    logic [15:0] lp;
    foreach (sh_valid[i]) sh_valid[i] = 1'b0;
    foreach (sh_tab[i]) sh_tab[i] = '0;
    sh_lport = 16'd0; sh_len = 1'b0; sh_win = 16'hFFFF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // listener disabled, defaults
    s = rnd_seg(); s.action = 1'b0; s.checksum_ok = 1'b1; s.flags = FL_SYN;
    s.dport = 16'd0; seg_q.push_back(s);
    s.checksum_ok = 1'b0; seg_q.push_back(s);
    s = rnd_seg(); s.action = 1'b1; s.conn_index = 4'd15; seg_q.push_back(s);
    drain();
    wr_reg(CFG_LISTEN_PORT, 16'hFFFF);
    wr_reg(CFG_LISTEN_ENABLE, 16'd1);
    wr_reg(CFG_WINDOW, 16'h0000);
    s = '1; s.action = 1'b0; s.flags = FL_SYN; seg_q.push_back(s);
    s.flags = FL_ACK; seg_q.push_back(s);
    s.flags = FL_PSH | FL_FIN; s.payload_length = 16'hFFFF; seg_q.push_back(s);
    s.flags = FL_PSH; s.payload_length = 16'd0; seg_q.push_back(s);
    s = '1; s.action = 1'b1; s.conn_index = 4'd0; seg_q.push_back(s);
    s = '1; s.action = 1'b0; s.flags = FL_ACK; seg_q.push_back(s);
    s = '0; s.checksum_ok = 1'b1; s.dport = 16'hFFFF; s.flags = FL_ACK;
    seg_q.push_back(s);
    // fill the table, then one more SYN
    for (int k = 0; k < CONN_ENTRIES + 1; k++) begin
      s = rnd_seg(); s.action = 1'b0; s.checksum_ok = 1'b1; s.dport = 16'hFFFF;
      s.flags = FL_SYN; seg_q.push_back(s);
    end
    drain();
    for (int k = 0; k < CONN_ENTRIES; k++) begin
      s = rnd_seg(); s.action = 1'b1; s.conn_index = 4'(k); seg_q.push_back(s);
    end
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      lp = (ph == 1) ? 16'd0 : 16'($urandom);
      wr_reg(CFG_LISTEN_PORT, lp);
      wr_reg(CFG_LISTEN_ENABLE, 16'(ph != 4));
      wr_reg(CFG_WINDOW, ph == 2 ? 16'hFFFF : 16'($urandom));
      for (int k = 0; k < 53; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          s = rnd_seg();
          if ($urandom_range(0, 1)) s.dport = lp;
          seg_q.push_back(s);
        end else conn_seq(lp, $urandom_range(0, 6));
      end
      drain();
    end
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### tcp_server_connection_tracker.f
hw/rtl/tsct_pkg.sv
hw/rtl/tsct_seg_if.sv
hw/rtl/tsct_table_ram.sv
hw/rtl/tcp_server_connection_tracker.sv
tb/tb.sv
